// ----- hw/rtl/scc_pkg.sv -----
// Shared types, codes and control structs for the SCC engine.
`default_nettype none
package scc_pkg;

  localparam int VW = 7;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_SOLVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]    mode;
    logic [VW-1:0] edge_from;
    logic [VW-1:0] edge_to;
  } in_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] component;
    logic [VW-1:0] component_total;
    logic          edge_overflow;
    logic          last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_ROOT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_LD,
    ST_P2_RD,
    ST_P2_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic add_edge;
    logic clear_graph;
    logic solve_init;
    logic next_root;
    logic start_walk;
    logic edge_rd;
    logic edge_chk;
    logic push;
    logic pop;
    logic stack_load;
    logic p2_init;
    logic p2_rd;
    logic emit_rd;
    logic emit_load;
    logic emit_adv;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       root_done;
    logic       root_visited;
    logic       scan_more;
    logic       scan_hit;
    logic       depth_full;
    logic       depth_last;
    logic       pass2;
    logic       p2_done;
    logic       p2_take;
    logic       emit_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/scc_ram.sv -----
// Generic one-write, one-read RAM with registered read data.
`default_nettype none
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                         wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/scc_ctrl.sv -----
// Sequencer that drives edge loading, both walk passes and result output.
`default_nettype none
module scc_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                out_ready,
  input  wire  scc_pkg::sts_t sts,
  output scc_pkg::cmd_t      cmd
);
  import scc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (sts.mode)
            MODE_ADD:   cmd.add_edge = 1'b1;
            MODE_CLEAR: cmd.clear_graph = 1'b1;
            MODE_SOLVE: begin
              cmd.solve_init = 1'b1;
              state_next     = ST_P1_ROOT;
            end
            default: ;
          endcase
        end
      end
      ST_P1_ROOT: begin
        if (sts.root_done) begin
          cmd.p2_init = 1'b1;
          state_next  = ST_P2_RD;
        end else if (sts.root_visited) begin
          cmd.next_root = 1'b1;
        end else begin
          cmd.start_walk = 1'b1;
          state_next     = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts.scan_more) begin
          cmd.edge_rd = 1'b1;
          state_next  = ST_SCAN_CHK;
        end else begin
          cmd.pop = 1'b1;
          if (!sts.depth_last) begin
            state_next = ST_POP_LD;
          end else if (sts.pass2) begin
            state_next = ST_P2_RD;
          end else begin
            cmd.next_root = 1'b1;
            state_next    = ST_P1_ROOT;
          end
        end
      end
      ST_SCAN_CHK: begin
        cmd.edge_chk = 1'b1;
        // a hit with a full stack keeps scanning from the same vertex
        if (sts.scan_hit && !sts.depth_full) begin
          cmd.push = 1'b1;
        end
        state_next = ST_SCAN_RD;
      end
      ST_POP_LD: begin
        cmd.stack_load = 1'b1;
        state_next     = ST_SCAN_RD;
      end
      ST_P2_RD: begin
        if (sts.p2_done) begin
          state_next = ST_EMIT_RD;
        end else begin
          cmd.p2_rd  = 1'b1;
          state_next = ST_P2_CHK;
        end
      end
      ST_P2_CHK: begin
        if (sts.p2_take) begin
          cmd.start_walk = 1'b1;
          state_next     = ST_SCAN_RD;
        end else begin
          state_next = ST_P2_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_next    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          state_next   = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/scc_dp.sv -----
// Datapath: edge store, walk stack, finish order, labels and counters.
`default_nettype none
module scc_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  scc_pkg::in_t  in_data,
  input  wire                 cfg_we,
  input  wire  [scc_pkg::VW-1:0] cfg_data,
  input  wire  scc_pkg::cmd_t cmd,
  output scc_pkg::sts_t       sts,
  output logic                out_valid,
  output scc_pkg::out_t       out_data
);
  import scc_pkg::*;

  localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SW  = VW + ECW;

  logic [VW-1:0]           vertex_count;
  logic [ECW-1:0]          edge_total;
  logic                    overflow;
  logic [VW-1:0]           n;
  logic                    pass2;
  logic [VW-1:0]           u;
  logic [DW-1:0]           k;
  logic [DW-1:0]           finished;
  logic [VW-1:0]           total;
  logic [VW-1:0]           cur_v;
  logic [ECW-1:0]          cur_c;
  logic [DW-1:0]           depth;
  logic [MAX_VERTICES-1:0] visited;

  logic [2*VW-1:0] edge_rdata;
  logic [SW-1:0]   stack_rdata;
  logic [VW-1:0]   fin_rdata;
  logic [VW-1:0]   comp_rdata;

  logic [VW-1:0]  n_eff;
  logic [VW-1:0]  ea, eb, sa, sb;
  logic           e_ok, f_ok;
  logic [VW-1:0]  root;
  logic [VW-1:0]  root_m1, sb_m1, u_m1, fin_m1;
  logic [DW-1:0]  depth_m1, depth_m2, k_m1;
  logic [ECW-1:0] cur_c_p1;

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = VW'(1);
    end else if (vertex_count > VW'(MAX_VERTICES)) begin
      n_eff = VW'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  assign ea = edge_rdata[2*VW-1:VW];
  assign eb = edge_rdata[VW-1:0];
  assign sa = pass2 ? eb : ea;
  assign sb = pass2 ? ea : eb;
  assign e_ok = (ea != '0) && (ea <= n) && (eb != '0) && (eb <= n);
  assign f_ok = (fin_rdata != '0) && (fin_rdata <= n);
  assign root     = pass2 ? fin_rdata : u;
  assign root_m1  = root - VW'(1);
  assign sb_m1    = sb - VW'(1);
  assign u_m1     = u - VW'(1);
  assign fin_m1   = fin_rdata - VW'(1);
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign k_m1     = k - DW'(1);
  assign cur_c_p1 = cur_c + ECW'(1);

  always_comb begin
    sts              = '0;
    sts.mode         = in_data.mode;
    sts.root_done    = u > n;
    sts.root_visited = visited[u_m1[VIW-1:0]];
    sts.scan_more    = cur_c < edge_total;
    sts.scan_hit     = e_ok && (sa == cur_v) && !visited[sb_m1[VIW-1:0]];
    sts.depth_full   = depth == DW'(MAX_VERTICES);
    sts.depth_last   = depth == DW'(1);
    sts.pass2        = pass2;
    sts.p2_done      = k == '0;
    sts.p2_take      = f_ok && !visited[fin_m1[VIW-1:0]];
    sts.emit_last    = u == n;
  end

  // edge store
  scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk  (clk),
    .we   (cmd.add_edge && (edge_total < ECW'(MAX_EDGES))),
    .waddr(edge_total[EIW-1:0]),
    .wdata({in_data.edge_from, in_data.edge_to}),
    .raddr(cur_c[EIW-1:0]),
    .rdata(edge_rdata)
  );

  // walk stack holds every level below the top
  scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(depth_m1[VIW-1:0]),
    .wdata({cur_v, cur_c_p1}),
    .raddr(depth_m2[VIW-1:0]),
    .rdata(stack_rdata)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fin_ram (
    .clk  (clk),
    .we   (cmd.pop && !pass2 && (finished < DW'(MAX_VERTICES))),
    .waddr(finished[VIW-1:0]),
    .wdata(cur_v),
    .raddr(k_m1[VIW-1:0]),
    .rdata(fin_rdata)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_comp_ram (
    .clk  (clk),
    .we   (pass2 && (cmd.start_walk || cmd.push)),
    .waddr(cmd.push ? sb_m1[VIW-1:0] : root_m1[VIW-1:0]),
    .wdata(cmd.push ? total : total + VW'(1)),
    .raddr(u_m1[VIW-1:0]),
    .rdata(comp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VW'(1);
      edge_total   <= '0;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
      visited      <= '0;
      pass2        <= 1'b0;
      depth        <= '0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (cmd.add_edge) begin
        if (edge_total < ECW'(MAX_EDGES)) begin
          edge_total <= edge_total + ECW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.clear_graph) begin
        edge_total <= '0;
        overflow   <= 1'b0;
      end
      if (cmd.solve_init) begin
        n        <= n_eff;
        visited  <= '0;
        pass2    <= 1'b0;
        u        <= VW'(1);
        finished <= '0;
        total    <= '0;
      end
      if (cmd.next_root) begin
        u <= u + VW'(1);
      end
      if (cmd.start_walk) begin
        visited[root_m1[VIW-1:0]] <= 1'b1;
        cur_v <= root;
        cur_c <= '0;
        depth <= DW'(1);
        if (pass2) begin
          total <= total + VW'(1);
        end
      end
      if (cmd.edge_chk) begin
        cur_c <= cur_c_p1;
      end
      if (cmd.push) begin
        visited[sb_m1[VIW-1:0]] <= 1'b1;
        cur_v <= sb;
        cur_c <= '0;
        depth <= depth + DW'(1);
      end
      if (cmd.pop) begin
        depth <= depth_m1;
        if (!pass2 && (finished < DW'(MAX_VERTICES))) begin
          finished <= finished + DW'(1);
        end
      end
      if (cmd.stack_load) begin
        cur_v <= stack_rdata[SW-1:ECW];
        cur_c <= stack_rdata[ECW-1:0];
      end
      if (cmd.p2_init) begin
        pass2   <= 1'b1;
        visited <= '0;
        k       <= finished;
        u       <= VW'(1);
      end
      if (cmd.p2_rd) begin
        k <= k_m1;
      end
      if (cmd.emit_load) begin
        out_valid                <= 1'b1;
        out_data.vertex          <= u;
        out_data.component       <= comp_rdata;
        out_data.component_total <= total;
        out_data.edge_overflow   <= overflow;
        out_data.last            <= u == n;
      end
      if (cmd.emit_adv) begin
        out_valid <= 1'b0;
        u         <= u + VW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/scc_kosaraju_engine.sv -----
// Strongly connected components engine: edges are stored in arrival order
// (one item per cycle for add and clear), and a solve item runs two
// depth-first passes over the edge memory and then returns one result per
// vertex, the last one flagged. Each edge examined during a walk is first
// read through the single read port of the edge memory and then checked,
// and every vertex scans the edge list from its saved cursor. Each result
// is read, loaded and then held until the consumer takes it. No new item
// is taken until every result of a solve has been delivered; vertex_count
// may be written at any time the block is idle.
`default_nettype none
module scc_kosaraju_engine #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  scc_pkg::in_t     in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output scc_pkg::out_t          out_data,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [scc_pkg::VW-1:0] cfg_data
);
  import scc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scc_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("engine not idle after final result");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.component != '0 &&
                   out_data.component <= out_data.component_total))
    else $error("component label outside found range");

  a_vertex_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=>
      (!out_valid || out_data.vertex == $past(out_data.vertex) + 7'd1))
    else $error("results out of vertex order");
endmodule
`default_nettype wire

// ----- bench/tb_scc_kosaraju_engine.sv -----
// Testbench for the SCC engine: random graphs, solves checked against a local model.
module tb_scc_kosaraju_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;

  class scc_scoreboard;
    logic [6:0] vcount;
    logic [6:0] src_mem[NE];
    logic [6:0] dst_mem[NE];
    int unsigned edge_cnt;
    bit overflow;
    out_t pending[$];
    int errors;

    function void reset_state();
      vcount = 1;
      edge_cnt = 0;
      overflow = 0;
      pending.delete();
    endfunction

    // One iterative depth-first walk; fills finish list or labels.
    function void dfs(int root, int n, bit back, bit rec, int id,
                      ref bit seen[NV+1], ref int fin[$], ref int comp[NV+1]);
      int stk_v[$];
      int stk_c[$];
      int v, c, nx, a, b, t;
      seen[root] = 1;
      if (!rec) comp[root] = id;
      stk_v.push_back(root);
      stk_c.push_back(0);
      while (stk_v.size() > 0) begin
        v = stk_v[$];
        c = stk_c[$];
        nx = 0;
        while (c < edge_cnt && nx == 0) begin
          a = src_mem[c];
          b = dst_mem[c];
          c++;
          if (a < 1 || a > n || b < 1 || b > n) continue;
          if (back) begin
            t = a; a = b; b = t;
          end
          if (a == v && !seen[b]) nx = b;
        end
        stk_c[$] = c;
        if (nx != 0 && stk_v.size() < NV) begin
          seen[nx] = 1;
          if (!rec) comp[nx] = id;
          stk_v.push_back(nx);
          stk_c.push_back(0);
        end else if (nx == 0) begin
          void'(stk_v.pop_back());
          void'(stk_c.pop_back());
          if (rec && fin.size() < NV) fin.push_back(v);
        end
      end
    endfunction

    function void note_input(in_t it);
      bit seen[NV+1];
      int fin[$];
      int comp[NV+1];
      int n, total, v;
      out_t r;
      case (it.mode)
        MODE_ADD: begin
          if (edge_cnt < NE) begin
            src_mem[edge_cnt] = it.edge_from;
            dst_mem[edge_cnt] = it.edge_to;
            edge_cnt++;
          end else begin
            overflow = 1;
          end
        end
        MODE_CLEAR: begin
          edge_cnt = 0;
          overflow = 0;
        end
        MODE_SOLVE: begin
          n = (vcount == 0) ? 1 : (vcount > NV) ? NV : vcount;
          foreach (seen[i]) seen[i] = 0;
          foreach (comp[i]) comp[i] = 0;
          for (int u = 1; u <= n; u++)
            if (!seen[u]) dfs(u, n, 0, 1, 0, seen, fin, comp);
          foreach (seen[i]) seen[i] = 0;
          total = 0;
          for (int i = fin.size() - 1; i >= 0; i--) begin
            v = fin[i];
            if (!seen[v]) begin
              total++;
              dfs(v, n, 1, 0, total, seen, fin, comp);
            end
          end
          for (int u = 1; u <= n; u++) begin
            r.vertex = 7'(u);
            r.component = 7'(comp[u]);
            r.component_total = 7'(total);
            r.edge_overflow = overflow;
            r.last = (u == n);
            pending.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item vertex=%0d", got.vertex));
        return;
      end
      exp = pending.pop_front();
      if (got.vertex !== exp.vertex)
        report($sformatf("vertex got %0d exp %0d", got.vertex, exp.vertex));
      if (got.component !== exp.component)
        report($sformatf("v%0d component got %0d exp %0d", exp.vertex,
                         got.component, exp.component));
      if (got.component_total !== exp.component_total)
        report($sformatf("v%0d total got %0d exp %0d", exp.vertex,
                         got.component_total, exp.component_total));
      if (got.edge_overflow !== exp.edge_overflow)
        report($sformatf("v%0d overflow got %0b exp %0b", exp.vertex,
                         got.edge_overflow, exp.edge_overflow));
      if (got.last !== exp.last)
        report($sformatf("v%0d last got %0b exp %0b", exp.vertex,
                         got.last, exp.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [VW-1:0] cfg_data = '0;

  scc_scoreboard sb = new();
  int stall_mode = 0;
  int n_cfg;

  scc_kosaraju_engine #(.MAX_VERTICES(NV), .MAX_EDGES(NE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Check results and drive the stall pattern of the receiver.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
  end

  task send_item(in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task idle_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_vcount(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.vcount = v;
    @(posedge clk);
  endtask

  function in_t mk(logic [1:0] m, logic [6:0] a, logic [6:0] b);
    in_t it;
    it.mode = m;
    it.edge_from = a;
    it.edge_to = b;
    return it;
  endfunction

  task random_graph(int nv, int ne);
    int burst;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < ne; i++) begin
      // Mostly in-range endpoints; sometimes anything the field allows.
      if ($urandom_range(0, 9) == 0)
        send_item(mk(MODE_ADD, $urandom_range(0, 127), $urandom_range(0, 127)));
      else
        send_item(mk(MODE_ADD, $urandom_range(1, nv), $urandom_range(1, nv)));
      if (--burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int nv, ne, sent;
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default single vertex, unused mode, cycle, self-loop, bad endpoints.
    send_item(mk(MODE_SOLVE, 0, 0));
    send_item(mk(2'd3, 7'h7f, 7'h7f));
    drain();
    write_vcount(4);
    send_item(mk(MODE_ADD, 1, 2));
    send_item(mk(MODE_ADD, 2, 1));
    send_item(mk(MODE_ADD, 3, 3));
    send_item(mk(MODE_ADD, 0, 4));
    send_item(mk(MODE_ADD, 4, 7'h7f));
    send_item(mk(MODE_ADD, 3, 4));
    send_item(mk(MODE_SOLVE, 7'h55, 7'h2a));
    send_item(mk(MODE_CLEAR, 7'h2a, 7'h55));
    send_item(mk(MODE_SOLVE, 0, 0));
    drain();
    write_vcount(0);
    send_item(mk(MODE_ADD, 1, 1));
    send_item(mk(MODE_SOLVE, 0, 0));
    drain();
    write_vcount(127);
    send_item(mk(MODE_ADD, 64, 1));
    send_item(mk(MODE_ADD, 1, 64));
    send_item(mk(MODE_ADD, 65, 64));
    send_item(mk(MODE_SOLVE, 0, 0));
    send_item(mk(MODE_CLEAR, 0, 0));
    drain();

    // Random phases with varied vertex counts.
    sent = 0;
    n_cfg = 0;
    while (sent < 260) begin
      case (n_cfg % 4)
        0: nv = 64;
        1: nv = $urandom_range(1, 3);
        default: nv = $urandom_range(2, 12);
      endcase
      n_cfg++;
      write_vcount(nv);
      ne = (nv == 64) ? $urandom_range(20, 50) : $urandom_range(0, 2 * nv + 2);
      random_graph(nv, ne);
      send_item(mk(MODE_SOLVE, $urandom, $urandom));
      if ($urandom_range(0, 2) == 0) begin
        random_graph(nv, $urandom_range(1, 4));
        send_item(mk(MODE_SOLVE, $urandom, $urandom));
      end
      send_item(mk(MODE_CLEAR, $urandom, $urandom));
      sent += ne + 3;
      drain();
    end

    // Fill the store past its capacity to raise the overflow flag.
    write_vcount(5);
    random_graph(5, NE + 3);
    send_item(mk(MODE_SOLVE, 0, 0));
    send_item(mk(MODE_CLEAR, 0, 0));
    send_item(mk(MODE_SOLVE, 0, 0));
    drain();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- scc_kosaraju_engine.f -----
hw/rtl/scc_pkg.sv
hw/rtl/scc_ram.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_dp.sv
hw/rtl/scc_kosaraju_engine.sv
bench/tb_scc_kosaraju_engine.sv
